// ===== hw/rtl/glyph_column_bitmap_expander_assert.svh =====
// Assertion macros used by the glyph column bitmap expander datapath module.
`ifndef GLYPH_COLUMN_BITMAP_EXPANDER_ASSERT_SVH
`define GLYPH_COLUMN_BITMAP_EXPANDER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define GCBE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("glyph expander check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define GCBE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("glyph expander check failed");

`endif

// ===== hw/rtl/gcbe_pkg.sv =====
// Shared types and constants of the glyph column bitmap expander.
`default_nettype none
package gcbe_pkg;

    localparam int MAX_GLYPH_HEIGHT = 64;
    // The six-bit row counter can count through 64 rows per column at most.
    localparam int ROW_COUNT_CAP = 64;

    localparam logic [7:0] TOP_BIT = 8'h80;
    localparam logic [2:0] BIT_LAST = 3'd7;

    // Register indexes of the configuration port.
    localparam logic [7:0] REG_GLYPH_HEIGHT = 8'd0;
    localparam logic [7:0] REG_TRANSPARENT  = 8'd1;
    localparam logic [7:0] REG_FORE_COLOR   = 8'd2;
    localparam logic [7:0] REG_BACK_COLOR   = 8'd3;

    localparam logic [6:0]  HEIGHT_RESET = 7'd16;
    localparam logic [15:0] FORE_RESET   = 16'h0000;
    localparam logic [15:0] BACK_RESET   = 16'hFFFF;

    typedef struct packed {
        logic [6:0]  height;      // already clamped to 1..row cap
        logic        transparent;
        logic [15:0] fore_color;
        logic [15:0] bg_color;
    } cfg_t;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [15:0] pixel_color;
        logic        write_enable;
        logic        last_of_byte;
    } pixel_t;

endpackage
`default_nettype wire

// ===== hw/rtl/gcbe_cfg.sv =====
// Configuration registers of the glyph column bitmap expander.
`default_nettype none
module gcbe_cfg #(
    parameter int MAX_GLYPH_HEIGHT = gcbe_pkg::MAX_GLYPH_HEIGHT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output gcbe_pkg::cfg_t          cfg
);

    localparam int ROW_CAP_INT = (MAX_GLYPH_HEIGHT < gcbe_pkg::ROW_COUNT_CAP) ?
                                 MAX_GLYPH_HEIGHT : gcbe_pkg::ROW_COUNT_CAP;
    localparam logic [6:0] ROW_CAP = 7'(ROW_CAP_INT);

    gcbe_pkg::cfg_t cfg_reg;
    gcbe_pkg::cfg_t cfg_next;
    logic [6:0]     height_in;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        height_in = cfg_data[6:0];
        if (height_in == 7'd0) begin
            height_in = 7'd1;
        end else if (height_in > ROW_CAP) begin
            height_in = ROW_CAP;
        end
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                gcbe_pkg::REG_GLYPH_HEIGHT: cfg_next.height      = height_in;
                gcbe_pkg::REG_TRANSPARENT:  cfg_next.transparent = cfg_data[0];
                gcbe_pkg::REG_FORE_COLOR:   cfg_next.fore_color  = cfg_data;
                gcbe_pkg::REG_BACK_COLOR:   cfg_next.bg_color    = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.height      <= gcbe_pkg::HEIGHT_RESET;
            cfg_reg.transparent <= 1'b0;
            cfg_reg.fore_color  <= gcbe_pkg::FORE_RESET;
            cfg_reg.bg_color    <= gcbe_pkg::BACK_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/gcbe_expand.sv =====
// Byte holding register, glyph position state and per-pixel logic.
`default_nettype none
`include "glyph_column_bitmap_expander_assert.svh"
module gcbe_expand (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire gcbe_pkg::cfg_t     cfg,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_glyph_byte,
    input  wire logic               s_new_glyph,
    input  wire logic [15:0]        s_origin_x,
    input  wire logic [15:0]        s_origin_y,
    input  wire logic               out_free,
    output logic                    pix_valid,
    output gcbe_pkg::pixel_t        pix
);

    logic        busy_reg,    busy_next;
    logic [7:0]  bits_reg,    bits_next;
    logic [2:0]  bit_idx_reg, bit_idx_next;
    logic [15:0] column_reg,  column_next;
    logic [15:0] top_row_reg, top_row_next;
    logic [5:0]  row_reg,     row_next;

    logic       step;
    logic       load;
    logic       bit_set;
    logic       col_end;
    logic       last;
    logic       we;
    logic [6:0] row_inc;

    always_comb begin
        step    = busy_reg && out_free;
        bit_set = (bits_reg & gcbe_pkg::TOP_BIT) != 8'd0;
        row_inc = {1'b0, row_reg} + 7'd1;
        col_end = row_inc >= cfg.height;
        last    = col_end || (bit_idx_reg == gcbe_pkg::BIT_LAST);
        we      = bit_set || !cfg.transparent;
        s_ready = !busy_reg || (step && last);
        load    = s_valid && s_ready;

        pix.pixel_x      = column_reg;
        pix.pixel_y      = top_row_reg + {10'd0, row_reg};
        pix.pixel_color  = we ? (bit_set ? cfg.fore_color : cfg.bg_color) : 16'd0;
        pix.write_enable = we;
        pix.last_of_byte = last;
        pix_valid        = step;

        busy_next    = busy_reg;
        bits_next    = bits_reg;
        bit_idx_next = bit_idx_reg;
        column_next  = column_reg;
        top_row_next = top_row_reg;
        row_next     = row_reg;

        // The pixel of the byte in hand is taken first; a byte loaded in the
        // same cycle then applies its origin on top of the updated state.
        if (step) begin
            bits_next    = {bits_reg[6:0], 1'b0};
            bit_idx_next = bit_idx_reg + 3'd1;
            if (col_end) begin
                row_next    = 6'd0;
                column_next = column_reg + 16'd1;
            end else begin
                row_next = row_inc[5:0];
            end
            if (last) begin
                busy_next = 1'b0;
            end
        end
        if (load) begin
            busy_next    = 1'b1;
            bits_next    = s_glyph_byte;
            bit_idx_next = 3'd0;
            if (s_new_glyph) begin
                column_next  = s_origin_x;
                top_row_next = s_origin_y;
                row_next     = 6'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg <= bits_next;
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            bit_idx_reg <= 3'd0;
            column_reg  <= 16'd0;
            top_row_reg <= 16'd0;
            row_reg     <= 6'd0;
        end else begin
            busy_reg    <= busy_next;
            bit_idx_reg <= bit_idx_next;
            column_reg  <= column_next;
            top_row_reg <= top_row_next;
            row_reg     <= row_next;
        end
    end

    `GCBE_ASSERT_NEXT(a_byte_done, aclk, aresetn, step && last && !load, !busy_reg)
    `GCBE_ASSERT_NEXT(a_load_starts, aclk, aresetn, load, busy_reg && bit_idx_reg == 3'd0)
    `GCBE_ASSERT_NEXT(a_col_end_row, aclk, aresetn, step && col_end, row_reg == 6'd0)
    `GCBE_ASSERT_NOW(a_no_accept_busy, aclk, aresetn, busy_reg && !out_free, !s_ready)

endmodule
`default_nettype wire

// ===== hw/rtl/gcbe_out_reg.sv =====
// Result register that holds one pixel beat until the consumer takes it.
`default_nettype none
module gcbe_out_reg (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               pix_valid,
    input  wire gcbe_pkg::pixel_t   pix,
    output logic                    out_free,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output gcbe_pkg::pixel_t        m_pix
);

    logic             valid_reg, valid_next;
    gcbe_pkg::pixel_t pix_reg,   pix_next;

    always_comb begin
        out_free   = !valid_reg || m_ready;
        valid_next = valid_reg;
        pix_next   = pix_reg;
        if (out_free) begin
            valid_next = pix_valid;
            if (pix_valid) begin
                pix_next = pix;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_pix   = pix_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/glyph_column_bitmap_expander.sv =====
// Top level of the glyph column bitmap expander.
`default_nettype none
// The block turns column-major glyph bitmap bytes into pixel write beats,
// one beat per bit, most significant bit first. A byte flagged with
// s_new_glyph first loads the glyph origin and restarts the row counter;
// otherwise the byte continues where the previous one stopped. When the row
// counter reaches the configured glyph height the column advances, the
// counter returns to zero and the remaining bits of that byte are dropped,
// so a byte yields between one and eight beats, and m_last_of_byte marks
// the final one. Rate: the single result register moves one pixel per
// cycle while the output side keeps taking beats; the next byte is
// accepted in the same cycle its predecessor issues its last beat, so
// bytes follow each other back to back while the output side keeps
// taking beats. Configuration goes through the cfg_ port,
// index 0 glyph height (0 acts as 1, values above the smaller of
// MAX_GLYPH_HEIGHT and 64 act as that limit, 64 by default),
// 1 transparent mode, 2 foreground color, 3 background color; other indexes
// are ignored. Write configuration only while no byte is in flight. In
// transparent mode clear bits still produce a beat, with m_write_enable low
// and a zero color. Coordinates wrap modulo 65536.
module glyph_column_bitmap_expander #(
    parameter int MAX_GLYPH_HEIGHT = gcbe_pkg::MAX_GLYPH_HEIGHT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_glyph_byte,
    input  wire logic        s_new_glyph,
    input  wire logic [15:0] s_origin_x,
    input  wire logic [15:0] s_origin_y,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_pixel_x,
    output logic [15:0]      m_pixel_y,
    output logic [15:0]      m_pixel_color,
    output logic             m_write_enable,
    output logic             m_last_of_byte
);

    gcbe_pkg::cfg_t   cfg;
    gcbe_pkg::pixel_t pix;
    gcbe_pkg::pixel_t m_pix;
    logic             pix_valid;
    logic             out_free;

    // Configuration registers; the height is stored already clamped.
    gcbe_cfg #(
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Holds the byte being expanded and the glyph position, and forms one
    // pixel per cycle whenever the result register can take it.
    gcbe_expand u_expand (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_glyph_byte (s_glyph_byte),
        .s_new_glyph  (s_new_glyph),
        .s_origin_x   (s_origin_x),
        .s_origin_y   (s_origin_y),
        .out_free     (out_free),
        .pix_valid    (pix_valid),
        .pix          (pix)
    );

    // Result register facing the consumer.
    gcbe_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pix_valid (pix_valid),
        .pix       (pix),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_pix     (m_pix)
    );

    assign m_pixel_x      = m_pix.pixel_x;
    assign m_pixel_y      = m_pix.pixel_y;
    assign m_pixel_color  = m_pix.pixel_color;
    assign m_write_enable = m_pix.write_enable;
    assign m_last_of_byte = m_pix.last_of_byte;

endmodule
`default_nettype wire

// ===== tb/tb_glyph_column_bitmap_expander.sv =====
// Self-checking testbench for the glyph column bitmap expander: directed, random and stall tests.
`timescale 1ns / 1ps

module tb_glyph_column_bitmap_expander;

    // The row counter holds 64 rows, so the usable height is capped there even if
    // the package allows taller fonts.
    localparam int ROWS_MAX = (gcbe_pkg::MAX_GLYPH_HEIGHT < 64) ?
                              gcbe_pkg::MAX_GLYPH_HEIGHT : 64;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic [7:0]  s_glyph_byte = '0;
    logic        s_new_glyph = 1'b0;
    logic [15:0] s_origin_x = '0;
    logic [15:0] s_origin_y = '0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [15:0] m_pixel_x;
    wire  [15:0] m_pixel_y;
    wire  [15:0] m_pixel_color;
    wire         m_write_enable;
    wire         m_last_of_byte;

    glyph_column_bitmap_expander uut (.*);

    // Free-running clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow copy of the configuration registers, updated on each accepted write beat.
    logic [6:0]  font_height = gcbe_pkg::HEIGHT_RESET;
    logic        transp_mode = 1'b0;
    logic [15:0] fore_rgb = gcbe_pkg::FORE_RESET;
    logic [15:0] back_rgb = gcbe_pkg::BACK_RESET;

    // Shadow copy of the drawing position: current column, glyph top row and the
    // row reached inside the current column.
    logic [15:0] pen_column = '0;
    logic [15:0] pen_top_row = '0;
    logic [5:0]  pen_row = '0;

    // Pixel beats predicted but not yet seen on the result channel, oldest first.
    gcbe_pkg::pixel_t pending_pixels[$];
    int     mismatch_count = 0;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int idle_pct = 0;
    int stall_pct = 0;

    // A test asks for a long receiver hold by bumping hold_requests; the ready
    // process notices the change and counts the hold down on its own.
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Expands one accepted glyph byte into the pixel beats it must produce and
    // queues them. The column ends when the row counter reaches the effective
    // height, which also covers a height lowered while a column is half drawn;
    // the bits left in the byte are then dropped.
    function automatic void expand_glyph_byte(input logic [7:0] bits, input logic new_glyph,
                                              input logic [15:0] origin_x,
                                              input logic [15:0] origin_y);
        gcbe_pkg::pixel_t px;
        int     rows;
        logic   bit_on;
        logic   column_done;
        rows = (font_height == 0) ? 1 : ((font_height > ROWS_MAX) ? ROWS_MAX : font_height);
        if (new_glyph) begin
            pen_column = origin_x;
            pen_top_row = origin_y;
            pen_row = '0;
        end
        for (int b = 7; b >= 0; b--) begin
            bit_on = bits[b];
            column_done = (int'(pen_row) + 1) >= rows;
            px.pixel_x = pen_column;
            px.pixel_y = pen_top_row + 16'(pen_row);
            px.write_enable = bit_on || !transp_mode;
            // A skipped pixel carries a zero color.
            px.pixel_color = !px.write_enable ? 16'h0000 : (bit_on ? fore_rgb : back_rgb);
            px.last_of_byte = column_done || (b == 0);
            pending_pixels.push_back(px);
            if (column_done) begin
                pen_row = '0;
                pen_column = pen_column + 16'd1;
                break;
            end
            pen_row = pen_row + 6'd1;
        end
    endfunction

    // Receiver: either sits out a requested long hold or stalls at random.
    always @(posedge aclk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker: every accepted beat is compared field by field with the
    // oldest predicted pixel.
    always @(posedge aclk) begin
        gcbe_pkg::pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected beat x=%h y=%h", m_pixel_x, m_pixel_y));
            end else begin
                want = pending_pixels.pop_front();
                if (m_pixel_x !== want.pixel_x)
                    report_mismatch($sformatf("pixel_x %h, expected %h",
                                              m_pixel_x, want.pixel_x));
                if (m_pixel_y !== want.pixel_y)
                    report_mismatch($sformatf("pixel_y %h, expected %h",
                                              m_pixel_y, want.pixel_y));
                if (m_pixel_color !== want.pixel_color)
                    report_mismatch($sformatf("pixel_color %h, expected %h",
                                              m_pixel_color, want.pixel_color));
                if (m_write_enable !== want.write_enable)
                    report_mismatch($sformatf("write_enable %b, expected %b",
                                              m_write_enable, want.write_enable));
                if (m_last_of_byte !== want.last_of_byte)
                    report_mismatch($sformatf("last_of_byte %b, expected %b",
                                              m_last_of_byte, want.last_of_byte));
            end
        end
    end

    // Offers one glyph byte after a random idle gap and waits until it is accepted.
    // Valid is left high on return so a following byte can go out back to back.
    task automatic send_glyph_byte(input logic [7:0] bits, input logic new_glyph,
                                   input logic [15:0] origin_x, input logic [15:0] origin_y);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_glyph_byte <= bits;
        s_new_glyph <= new_glyph;
        s_origin_x <= origin_x;
        s_origin_y <= origin_y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expand_glyph_byte(bits, new_glyph, origin_x, origin_y);
    endtask

    // Drops valid and waits until every predicted pixel has come out.
    task automatic wait_pixels_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_pixels.size() != 0);
    endtask

    task automatic write_register(input logic [7:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            gcbe_pkg::REG_GLYPH_HEIGHT: font_height = value[6:0];
            gcbe_pkg::REG_TRANSPARENT:  transp_mode = value[0];
            gcbe_pkg::REG_FORE_COLOR:   fore_rgb = value;
            gcbe_pkg::REG_BACK_COLOR:   back_rgb = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Registers are only rewritten once the block has nothing left in flight.
    task automatic apply_settings(input logic [6:0] height, input logic transparent,
                                  input logic [15:0] fore, input logic [15:0] back);
        wait_pixels_drained();
        write_register(gcbe_pkg::REG_GLYPH_HEIGHT, {9'd0, height});
        write_register(gcbe_pkg::REG_TRANSPARENT, {15'd0, transparent});
        write_register(gcbe_pkg::REG_FORE_COLOR, fore);
        write_register(gcbe_pkg::REG_BACK_COLOR, back);
    endtask

    // Origins land near the top of the address space a quarter of the time so
    // that columns and rows wrap around.
    function automatic logic [15:0] random_coord();
        return ($urandom_range(3) == 0) ? 16'hFFF0 + 16'($urandom_range(15))
                                        : 16'($urandom());
    endfunction

    function automatic logic [15:0] random_color();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // Mostly small fonts so columns end inside bytes, with the out-of-range
    // and maximum heights mixed in.
    function automatic logic [6:0] random_height();
        case ($urandom_range(9))
            0: return 7'd0;
            1: return 7'd64;
            2: return 7'($urandom_range(65, 127));
            3: return 7'($urandom_range(17, 63));
            default: return 7'($urandom_range(1, 16));
        endcase
    endfunction

    // Sends glyphs as a start byte followed by continuation bytes with random
    // bitmaps. About one byte in ten flips its start flag, giving stray origin
    // reloads and glyphs that run on without a start.
    task automatic send_glyph_stream(input int n_bytes);
        int          sent;
        int          glyph_len;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [7:0]  bits;
        logic        start;
        sent = 0;
        while (sent < n_bytes) begin
            ox = random_coord();
            oy = random_coord();
            glyph_len = $urandom_range(1, 12);
            for (int i = 0; i < glyph_len && sent < n_bytes; i++) begin
                case ($urandom_range(9))
                    0: bits = 8'h00;
                    1: bits = 8'hFF;
                    default: bits = 8'($urandom());
                endcase
                start = (i == 0);
                if ($urandom_range(9) == 0) begin
                    start = !start;
                    ox = random_coord();
                    oy = random_coord();
                end
                send_glyph_byte(bits, start, ox, oy);
                sent++;
            end
        end
    endtask

    // Reset values: default height, opaque, black on white, and bytes before
    // any glyph start drawn from the origin at (0, 0).
    task automatic test_reset_defaults();
        send_glyph_byte(8'hA5, 1'b0, 16'h1234, 16'h5678);
        send_glyph_byte(8'hFF, 1'b0, 16'hFFFF, 16'hFFFF);
        send_glyph_byte(8'h00, 1'b0, 16'h0000, 16'h0000);
    endtask

    // Origins at the field extremes; the second glyph wraps both its rows and
    // its column past 65535, and its last byte lands in column zero.
    task automatic test_origin_extremes();
        send_glyph_byte(8'h81, 1'b1, 16'h0000, 16'h0000);
        send_glyph_byte(8'h7E, 1'b1, 16'hFFFF, 16'hFFFC);
        send_glyph_byte(8'hC3, 1'b0, 16'h0000, 16'h0000);
        send_glyph_byte(8'h18, 1'b0, 16'h0000, 16'h0000);
    endtask

    // Transparent mode: clear bits come out with write enable low and a zero color.
    task automatic test_transparent_mode();
        apply_settings(7'd16, 1'b1, 16'hFFFF, 16'h1234);
        send_glyph_byte(8'h5A, 1'b1, 16'h0100, 16'h0200);
        send_glyph_byte(8'h00, 1'b0, 16'h0000, 16'h0000);
        send_glyph_byte(8'hFF, 1'b0, 16'h0000, 16'h0000);
    endtask

    // Height extremes: one row per column, zero acting as one, a height that
    // ends the column mid-byte, and an oversized value acting as 64.
    task automatic test_height_limits();
        apply_settings(7'd1, 1'b0, 16'hF800, 16'h001F);
        send_glyph_byte(8'hFF, 1'b1, 16'h0010, 16'h0020);
        send_glyph_byte(8'h00, 1'b0, 16'h0000, 16'h0000);
        apply_settings(7'd0, 1'b1, 16'h07E0, 16'h0000);
        send_glyph_byte(8'h7F, 1'b1, 16'h0030, 16'h0040);
        apply_settings(7'd3, 1'b0, 16'hAAAA, 16'h5555);
        send_glyph_byte(8'hB6, 1'b1, 16'h0050, 16'h0060);
        apply_settings(7'd127, 1'b0, 16'h0001, 16'h8000);
        for (int i = 0; i < 8; i++)
            send_glyph_byte(8'($urandom()), i == 0, 16'h0070, 16'hFFE0);
    endtask

    // Height lowered below the row already reached: the next byte ends the
    // column at its first bit.
    task automatic test_height_lowered();
        apply_settings(7'd16, 1'b0, 16'h1111, 16'h2222);
        send_glyph_byte(8'h96, 1'b1, 16'h0400, 16'h0500);
        apply_settings(7'd5, 1'b0, 16'h1111, 16'h2222);
        send_glyph_byte(8'h69, 1'b0, 16'h0000, 16'h0000);
    endtask

    // Random glyph streams under one idling pattern, with two random settings.
    task automatic test_random_glyphs(input int idle, input int stall, input int n_bytes);
        idle_pct = idle;
        stall_pct = stall;
        repeat (2) begin
            apply_settings(random_height(), 1'($urandom_range(1)), random_color(),
                           random_color());
            send_glyph_stream(n_bytes / 2);
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // bytes, so the block fills up and has to stall its input.
    task automatic test_output_hold();
        idle_pct = 0;
        stall_pct = 0;
        apply_settings(7'd64, 1'b0, 16'hFFFF, 16'h0000);
        hold_requests++;
        send_glyph_stream(24);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_origin_extremes();
        test_transparent_mode();
        test_height_limits();
        test_height_lowered();
        test_random_glyphs(0, 0, 90);
        test_random_glyphs(84, 0, 84);
        test_random_glyphs(0, 84, 84);
        test_random_glyphs(27, 27, 90);
        test_output_hold();

        // Let everything drain, then watch a little longer for stray beats.
        wait_pixels_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS glyph_column_bitmap_expander");
        end else begin
            $display("FAIL glyph_column_bitmap_expander");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, which stays well under this.
    initial begin
        #2000000;
        $display("FAIL glyph_column_bitmap_expander");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/gcbe_pkg.sv
hw/rtl/gcbe_cfg.sv
hw/rtl/gcbe_expand.sv
hw/rtl/gcbe_out_reg.sv
hw/rtl/glyph_column_bitmap_expander.sv
tb/tb_glyph_column_bitmap_expander.sv
